[src/rsmq_pkg.sv]
package rsmq_pkg;

	// Field and port widths
	localparam int WORD_W    = 32;
	localparam int IDX_W     = 12;
	localparam int CNT_CFG_W = 13;
	localparam int CFG_IDX_W = 2;

	// Default polynomial length limit
	localparam int unsigned MAX_COEFFS_DEF = 4096;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd2;

	// Reset values and fixed limits
	localparam logic [WORD_W-1:0]    MODULUS_RESET = 32'd2;
	localparam logic [CNT_CFG_W-1:0] COUNT_RESET   = 13'd4096;
	localparam logic [WORD_W-1:0]    FULL_WORD     = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0]    TERNARY_LIMIT = 32'hFFFF_FFFE;
	localparam logic [WORD_W-1:0]    TERNARY_DIV   = 32'd3;

	// Reciprocal pass: one quotient bit of (2^64 - 1) / d per cycle
	localparam int RECIP_STEPS = 2 * 2 * WORD_W / 2;
	localparam int STEP_W      = $clog2(RECIP_STEPS);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Settings seen by front and back
	typedef struct packed {
		logic [WORD_W-1:0]   q_eff;
		logic [WORD_W-1:0]   divisor;
		logic [2*WORD_W-1:0] recip;
		logic [WORD_W-1:0]   threshold;
		logic                ternary;
		logic                busy;
	} cfg_t;

	// Accepted word with its position tags
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [IDX_W-1:0]  idx;
		logic              last;
	} item_t;

endpackage

[src/rsmq_cfg.sv]
module rsmq_cfg
	import rsmq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output cfg_t                 cfg,
	output logic [CNT_CFG_W-1:0] poly_size
);

	logic [WORD_W-1:0]    modulus_q;
	logic                 mode_q;
	logic [CNT_CFG_W-1:0] count_q;
	logic                 busy_q;
	logic [STEP_W-1:0]    step_q;
	logic [WORD_W-1:0]    rem_q;
	logic [2*WORD_W-1:0]  quo_q;
	logic [2*WORD_W-1:0]  recip_q;
	logic [WORD_W-1:0]    thr_q;
	logic                 wr;
	logic [WORD_W-1:0]    q_eff;
	logic [WORD_W-1:0]    div;
	logic [WORD_W:0]      rem_sh;
	logic                 ge;
	logic [WORD_W:0]      rem_sub;
	logic [WORD_W-1:0]    rem_n;

	assign wr        = cfg_valid & cfg_ready;
	assign cfg_ready = ~busy_q;

	// Modulus below two behaves as two
	assign q_eff = (modulus_q < MODULUS_RESET) ? MODULUS_RESET : modulus_q;
	assign div   = mode_q ? TERNARY_DIV : q_eff;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			mode_q    <= 1'b0;
			count_q   <= COUNT_RESET;
		end else if (wr) begin
			case (cfg_index)
				REG_MODULUS: modulus_q <= cfg_data;
				REG_MODE:    mode_q    <= cfg_data[0];
				REG_COUNT:   count_q   <= cfg_data[CNT_CFG_W-1:0];
				default:     ;
			endcase
		end
	end

	// Restoring division step, dividend bits are all ones
	always_comb begin
		rem_sh  = {rem_q, 1'b1};
		ge      = rem_sh >= {1'b0, div};
		rem_sub = rem_sh - {1'b0, div};
		rem_n   = ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
	end

	// Reciprocal pass after reset and after every write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			step_q <= '0;
			rem_q  <= '0;
		end else if (wr) begin
			busy_q <= 1'b1;
			step_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_n;
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(RECIP_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Quotient, reciprocal and threshold
	always_ff @(posedge clk) begin
		if (busy_q) begin
			quo_q <= {quo_q[2*WORD_W-2:0], ge};
			if (step_q == STEP_W'(RECIP_STEPS - 1)) begin
				recip_q <= {quo_q[2*WORD_W-2:0], ge};
			end
			// half way the remainder is 0xFFFFFFFF mod d
			if (step_q == STEP_W'(RECIP_STEPS / 2 - 1)) begin
				thr_q <= mode_q ? TERNARY_LIMIT : (FULL_WORD - rem_n - WORD_W'(1));
			end
		end
	end

	assign cfg.q_eff     = q_eff;
	assign cfg.divisor   = div;
	assign cfg.recip     = recip_q;
	assign cfg.threshold = thr_q;
	assign cfg.ternary   = mode_q;
	assign cfg.busy      = busy_q;
	assign poly_size     = count_q;

endmodule

[src/rsmq_front.sv]
module rsmq_front
	import rsmq_pkg::*;
#(
	parameter int unsigned MAX_COEFFS = MAX_COEFFS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [WORD_W-1:0]    rand_word,
	input  cfg_t                 cfg,
	input  logic [CNT_CFG_W-1:0] poly_size,
	output logic                 item_valid,
	output item_t                item,
	input  logic                 item_take
);

	localparam int CNT_W = $clog2(MAX_COEFFS);
	localparam int NW    = ($clog2(MAX_COEFFS + 1) > CNT_CFG_W) ?
	                       $clog2(MAX_COEFFS + 1) : CNT_CFG_W;

	logic [CNT_W-1:0]       cnt_q;
	logic [NW-1:0]          cc_ext;
	logic [NW-1:0]          n_eff;
	logic [NW:0]            cnt_inc;
	logic                   last;
	logic [CNT_W+IDX_W-1:0] idx_ext;
	logic                   accept;
	logic                   keep;
	item_t                  mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]      wr_ptr_q;
	logic [QPTR_W-1:0]      rd_ptr_q;
	logic [QCNT_W-1:0]      fill_q;
	logic                   q_full;
	logic                   q_empty;
	logic                   rd;

	// Effective polynomial length, clamped to 1..MAX_COEFFS
	always_comb begin
		cc_ext = NW'(poly_size);
		if (poly_size == '0) begin
			n_eff = NW'(1);
		end else if (cc_ext > NW'(MAX_COEFFS)) begin
			n_eff = NW'(MAX_COEFFS);
		end else begin
			n_eff = cc_ext;
		end
	end

	// Classify: reject at or above threshold, tag position
	assign cnt_inc = {1'b0, NW'(cnt_q)} + (NW+1)'(1);
	assign last    = cnt_inc >= {1'b0, n_eff};
	assign idx_ext = {{IDX_W{1'b0}}, cnt_q};

	assign q_full  = fill_q == QCNT_W'(QUEUE_DEPTH);
	assign q_empty = fill_q == '0;
	assign full    = cfg.busy | q_full;
	assign accept  = push & ~full;
	assign keep    = accept & (rand_word < cfg.threshold);
	assign rd      = item_take & ~q_empty;

	// Coefficient counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (keep) begin
			cnt_q <= last ? '0 : cnt_inc[CNT_W-1:0];
		end
	end

	// Queue towards the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (keep) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd)   rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({keep, rd})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			mem_q[wr_ptr_q].word <= rand_word;
			mem_q[wr_ptr_q].idx  <= idx_ext[IDX_W-1:0];
			mem_q[wr_ptr_q].last <= last;
		end
	end

	assign item_valid = ~q_empty;
	assign item       = mem_q[rd_ptr_q];

endmodule

[src/rsmq_back.sv]
module rsmq_back
	import rsmq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              item_valid,
	input  item_t             item,
	output logic              item_take,
	output logic              empty,
	input  logic              pop,
	output logic [WORD_W-1:0] coefficient,
	output logic [IDX_W-1:0]  coeff_index,
	output logic              last_coeff
);

	localparam int DW = WORD_W + 2;

	logic                  adv;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2*WORD_W-1:0]   plo_s1, phi_s1;
	logic [WORD_W-1:0]     word_s1, word_s2, word_s3;
	logic [IDX_W-1:0]      idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic                  last_s1, last_s2, last_s3, last_s4, last_s5;
	logic [2*WORD_W-1:0]   qsum;
	logic [WORD_W-1:0]     qhat_s2;
	logic [2*WORD_W-1:0]   prod;
	logic [DW-1:0]         prod_s3;
	logic [DW-1:0]         diff;
	logic [WORD_W:0]       diff_s4;
	logic [WORD_W:0]       red_sub;
	logic [WORD_W-1:0]     r;
	logic [WORD_W-1:0]     coef;
	logic [WORD_W-1:0]     coef_s5;

	// Whole pipe moves when the result slot is free or being taken
	assign adv       = ~v_s5 | pop;
	assign item_take = adv & item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// s1: word times reciprocal, two 32x32 halves
	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s1  <= (2*WORD_W)'(item.word) * (2*WORD_W)'(cfg.recip[WORD_W-1:0]);
			phi_s1  <= (2*WORD_W)'(item.word) * (2*WORD_W)'(cfg.recip[2*WORD_W-1:WORD_W]);
			word_s1 <= item.word;
			idx_s1  <= item.idx;
			last_s1 <= item.last;
		end
	end

	// s2: quotient estimate, true quotient or one below
	assign qsum = phi_s1 + {{WORD_W{1'b0}}, plo_s1[2*WORD_W-1:WORD_W]};

	always_ff @(posedge clk) begin
		if (adv) begin
			qhat_s2 <= qsum[2*WORD_W-1:WORD_W];
			word_s2 <= word_s1;
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
		end
	end

	// s3: estimate times divisor, low bits only
	assign prod = (2*WORD_W)'(qhat_s2) * (2*WORD_W)'(cfg.divisor);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= prod[DW-1:0];
			word_s3 <= word_s2;
			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
		end
	end

	// s4: partial remainder, below twice the divisor
	assign diff = DW'(word_s3) - prod_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s4 <= diff[WORD_W:0];
			idx_s4  <= idx_s3;
			last_s4 <= last_s3;
		end
	end

	// s5: final correction and ternary mapping
	always_comb begin
		red_sub = diff_s4 - {1'b0, cfg.divisor};
		r       = (diff_s4 >= {1'b0, cfg.divisor}) ? red_sub[WORD_W-1:0] : diff_s4[WORD_W-1:0];
		if (!cfg.ternary) begin
			coef = r;
		end else if (r == '0) begin
			coef = cfg.q_eff - WORD_W'(1);
		end else begin
			coef = r - WORD_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_s5 <= coef;
			idx_s5  <= idx_s4;
			last_s5 <= last_s4;
		end
	end

	assign empty       = ~v_s5;
	assign coefficient = coef_s5;
	assign coeff_index = idx_s5;
	assign last_coeff  = last_s5;

endmodule

[src/rejection_sampler_mod_q_top.sv]
// Rejection sampler: turns 32-bit random words into polynomial coefficients mod q.
// Input queue side: a request is taken when push is high and full is low. Words at
// or above the rejection threshold are dropped and produce no result.
// Result queue side: while empty is low the oldest result sits on coefficient,
// coeff_index and last_coeff; pop high takes it.
// Configuration: cfg_index selects modulus (0), sample mode (1) or polynomial
// length (2); a request completes when cfg_valid and cfg_ready are both high.
// Other indexes are ignored.
// Throughput is one word per cycle while full is low. A kept word passes the queue
// write, then five pipeline stages of the Barrett reduction with its three
// multipliers, before it can be popped.
// After reset and after every configuration write the divider computes the
// reciprocal and threshold one bit a cycle; while it runs full is high and
// cfg_ready is low. Reset and the last coefficient clear the coefficient counter.
// When the receiver stalls the pipeline holds, a four-entry queue between the
// classifier and the reduction absorbs further words, then full rises.
module rejection_sampler_mod_q_top
	import rsmq_pkg::*;
#(
	parameter int unsigned MAX_COEFFS = MAX_COEFFS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [WORD_W-1:0]    rand_word,
	output logic                 empty,
	input  logic                 pop,
	output logic [WORD_W-1:0]    coefficient,
	output logic [IDX_W-1:0]     coeff_index,
	output logic                 last_coeff,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	cfg_t                 cfg;
	logic [CNT_CFG_W-1:0] poly_size;
	logic                 item_valid;
	item_t                item;
	logic                 item_take;

	// Settings and reciprocal unit
	rsmq_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg        (cfg),
		.poly_size  (poly_size)
	);

	// Classifier, counter and queue
	rsmq_front #(
		.MAX_COEFFS(MAX_COEFFS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rand_word  (rand_word),
		.cfg        (cfg),
		.poly_size  (poly_size),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	// Modular reduction pipeline
	rsmq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.empty      (empty),
		.pop        (pop),
		.coefficient(coefficient),
		.coeff_index(coeff_index),
		.last_coeff (last_coeff)
	);

endmodule

[src/rsmq_checker.sv]
module rsmq_checker
	import rsmq_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 full,
	input logic                 empty,
	input logic                 pop,
	input logic [WORD_W-1:0]    coefficient,
	input logic [IDX_W-1:0]     coeff_index,
	input logic                 last_coeff,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	logic [IDX_W-1:0] exp_idx_q;
	logic             out_req;

	assign out_req = pop & ~empty;

	// Index expected on the next result request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_req) begin
			exp_idx_q <= last_coeff ? '0 : coeff_index + 1'b1;
		end
	end

	// Results are numbered without gaps, restarting after the last one
	a_idx_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_req |-> coeff_index == exp_idx_q)
		else $error("coefficient index out of sequence");

	// A settings write starts a reciprocal pass that blocks both channels
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (full && !cfg_ready))
		else $error("block open during reciprocal pass");

	// Coming out of reset the reciprocal pass is running
	a_reset_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (full && !cfg_ready))
		else $error("block open straight after reset");

	// A waiting result is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(coefficient) && $stable(coeff_index)))
		else $error("waiting result changed");

endmodule

bind rejection_sampler_mod_q_top rsmq_checker u_rsmq_checker (.*);

[sim/coeff_checker.sv]
`timescale 1ns / 1ps

// Watches the word, result and register channels, predicts each coefficient
// and compares it with what the sampler hands out.
module coeff_checker
	import rsmq_pkg::*;
#(
	parameter int unsigned MAX_COEFFS = MAX_COEFFS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic [WORD_W-1:0]    rand_word,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [WORD_W-1:0]    coefficient,
	input  logic [IDX_W-1:0]     coeff_index,
	input  logic                 last_coeff,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [WORD_W-1:0] coef;
		logic [IDX_W-1:0]  idx;
		logic              is_last;
	} coeff_t;

	// Coefficients predicted but not yet popped, oldest first
	coeff_t expected_coeffs[$];

	// Shadow copy of the registers and the sampler state
	logic [WORD_W-1:0]    modulus_q;
	logic                 ternary_mode;
	logic [CNT_CFG_W-1:0] poly_len;
	logic [WORD_W-1:0]    keep_below;
	int unsigned          next_idx;

	// Moduli below two behave as two
	function automatic logic [WORD_W-1:0] ring_modulus();
		return (modulus_q < 2) ? WORD_W'(2) : modulus_q;
	endfunction

	// Words at or above this are dropped
	function automatic logic [WORD_W-1:0] keep_limit();
		if (ternary_mode)
			return TERNARY_LIMIT;
		return FULL_WORD - (FULL_WORD % ring_modulus()) - WORD_W'(1);
	endfunction

	task automatic report(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : model
		coeff_t            want;
		logic [WORD_W-1:0] q;
		logic [WORD_W-1:0] coef;
		logic [WORD_W-1:0] t;
		int unsigned       len;
		logic              is_last;

		if (!arst_n) begin
			expected_coeffs.delete();
			modulus_q    = MODULUS_RESET;
			ternary_mode = 1'b0;
			poly_len     = COUNT_RESET;
			next_idx     = 0;
			keep_below   = keep_limit();
			errors       = 0;
			pending      = 0;
		end else begin
			// Result side: compare against the oldest prediction
			if (pop && !empty) begin
				if (expected_coeffs.size() == 0) begin
					report($sformatf("coefficient %h idx %0d popped with nothing expected",
						coefficient, coeff_index));
				end else begin
					want = expected_coeffs.pop_front();
					if (coefficient !== want.coef)
						report($sformatf("coefficient %h, expected %h (idx %0d)",
							coefficient, want.coef, want.idx));
					if (coeff_index !== want.idx)
						report($sformatf("coeff_index %0d, expected %0d",
							coeff_index, want.idx));
					if (last_coeff !== want.is_last)
						report($sformatf("last_coeff %b, expected %b (idx %0d)",
							last_coeff, want.is_last, want.idx));
				end
			end

			// Register writes; unknown indexes change nothing
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODULUS: modulus_q = cfg_data;
					REG_MODE:    ternary_mode = cfg_data[0];
					REG_COUNT:   poly_len = cfg_data[CNT_CFG_W-1:0];
					default: ;
				endcase
				keep_below = keep_limit();
			end

			// Word side: kept words produce one coefficient each
			if (push && !full && rand_word < keep_below) begin
				q = ring_modulus();
				if (poly_len == 0)
					len = 1;
				else if (poly_len > MAX_COEFFS)
					len = MAX_COEFFS;
				else
					len = poly_len;
				if (ternary_mode) begin
					t = rand_word % TERNARY_DIV;
					coef = (t == 0) ? q - WORD_W'(1) : t - WORD_W'(1);
				end else begin
					coef = rand_word % q;
				end
				// counter may already sit past a shortened length
				is_last = (next_idx + 1 >= len);
				expected_coeffs.push_back('{coef, next_idx[IDX_W-1:0], is_last});
				next_idx = is_last ? 0 : next_idx + 1;
			end

			pending = expected_coeffs.size();
		end
	end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
	import rsmq_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 12;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [WORD_W-1:0]    rand_word = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [WORD_W-1:0]    coefficient;
	logic [IDX_W-1:0]     coeff_index;
	logic                 last_coeff;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;

	int errors;
	int pending;

	// Idle rates in percent, and a long receiver hold-off counted by the pop loop
	int send_idle = 0;
	int recv_idle = 0;
	int hold_len = 0;

	always #2 clk = ~clk;

	rejection_sampler_mod_q_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rand_word  (rand_word),
		.empty      (empty),
		.pop        (pop),
		.coefficient(coefficient),
		.coeff_index(coeff_index),
		.last_coeff (last_coeff),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	coeff_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rand_word  (rand_word),
		.empty      (empty),
		.pop        (pop),
		.coefficient(coefficient),
		.coeff_index(coeff_index),
		.last_coeff (last_coeff),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.pending    (pending)
	);

	// Offer one word and hold it until the sampler takes the request
	task automatic offer_word(input logic [WORD_W-1:0] w);
		push <= 1'b1;
		rand_word <= w;
		do @(posedge clk); while (full);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending, wait for every predicted coefficient, then let the
	// sampler idle
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One random configuration followed by a burst of words
	task automatic sample_round(input int n_words, input int stall_len);
		logic [WORD_W-1:0] val;
		logic [WORD_W-1:0] w;

		settle();
		if ($urandom_range(0, 9) < 7) begin
			case ($urandom_range(0, 9))
				0: val = 32'd0;
				1: val = 32'd1;
				2: val = 32'd2;
				3: val = 32'd3;
				4: val = FULL_WORD;
				5: val = 32'h8000_0001;
				6: val = 32'h8000_0000;
				7: val = $urandom_range(4, 5000);
				default: val = $urandom;
			endcase
			write_reg(REG_MODULUS, val);
		end
		if ($urandom_range(0, 9) < 7)
			write_reg(REG_MODE, $urandom);
		if ($urandom_range(0, 9) < 7) begin
			case ($urandom_range(0, 7))
				0: val = 32'd0;
				1: val = 32'd1;
				2: val = 32'(COUNT_RESET);
				3: val = 32'h1FFF;
				4: val = $urandom;
				default: val = $urandom_range(2, 24);
			endcase
			write_reg(REG_COUNT, val);
		end
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_UNUSED, $urandom);

		hold_len = stall_len;
		for (int i = 0; i < n_words; i++) begin
			// sender gap with junk on the word lines
			if ($urandom_range(0, 99) < send_idle) begin
				push <= 1'b0;
				rand_word <= $urandom;
				@(posedge clk);
			end
			// bias towards the ends of the range and the half-range threshold
			case ($urandom_range(0, 9))
				0: w = FULL_WORD - $urandom_range(0, 7);
				1: w = $urandom_range(0, 7);
				2: w = 32'h8000_0000 + $urandom_range(0, 7) - 32'd4;
				default: w = $urandom;
			endcase
			offer_word(w);
			// once per stalled round, pause until everything has drained
			if (stall_len > 0 && i == n_words / 2)
				settle();
		end
	endtask

	// Receiver: random pop, or a long hold-off when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				pop <= 1'b0;
				hold_len--;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	initial begin
		logic [WORD_W-1:0] uni_words [8] = '{32'h0, 32'h1, 32'hFFFF_FFFC, 32'hFFFF_FFFD,
			32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
		logic [WORD_W-1:0] tern_words [6] = '{32'h0, 32'h1, 32'h2, 32'hFFFF_FFFD,
			32'hFFFF_FFFE, 32'hFFFF_FFFF};
		logic [WORD_W-1:0] wide_words [5] = '{32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'hFFFF_FFFF,
			32'h0, 32'h1234_5678};
		int idle_pairs [3][2] = '{'{14, 53}, '{53, 14}, '{0, 0}};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: q of two, uniform, full-length polynomial
		foreach (uni_words[i]) offer_word(uni_words[i]);
		settle();

		// Counter already past a length of one; modulus zero acts as two; ternary
		write_reg(REG_COUNT, 32'd0);
		write_reg(REG_MODE, 32'd1);
		write_reg(REG_MODULUS, 32'd0);
		foreach (tern_words[i]) offer_word(tern_words[i]);
		settle();

		// Largest modulus, length above the limit is clamped
		write_reg(REG_MODULUS, FULL_WORD);
		write_reg(REG_MODE, 32'd0);
		write_reg(REG_COUNT, 32'h1FFF);
		foreach (wide_words[i]) offer_word(wide_words[i]);
		settle();

		// Modulus one acts as two, short polynomial wraps, unknown index ignored
		write_reg(REG_MODULUS, 32'd1);
		write_reg(REG_COUNT, 32'd3);
		write_reg(REG_UNUSED, FULL_WORD);
		repeat (7) offer_word($urandom);

		// Random part under three idling regimes
		for (int p = 0; p < 3; p++) begin
			send_idle = idle_pairs[p][0];
			recv_idle = idle_pairs[p][1];
			for (int r = 0; r < 3; r++)
				sample_round(120, (r == 0 && p != 1) ? 150 : 0);
		end

		push <= 1'b0;
		for (int i = 0; i < 20000 && pending != 0; i++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending != 0)
			$display("ERROR: %0d coefficients never arrived", pending);
		if (errors == 0 && pending == 0) begin
			$display("PASS rejection_sampler_mod_q_top");
		end else begin
			$display("FAIL rejection_sampler_mod_q_top");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("FAIL rejection_sampler_mod_q_top");
		$finish;
	end

endmodule

[rejection_sampler_mod_q_top.f]
src/rsmq_pkg.sv
src/rsmq_cfg.sv
src/rsmq_front.sv
src/rsmq_back.sv
src/rejection_sampler_mod_q_top.sv
src/rsmq_checker.sv
sim/coeff_checker.sv
sim/tb.sv
